>>> src/ppca_pkg.sv
// Package: shared types and constants for the p-persistent channel access controller.
package ppca_pkg;

  localparam int unsigned RAND_BYTE_MAX    = 255;
  localparam int unsigned RANDOM_W         = 8;
  localparam int unsigned PERSIST_W        = 8;
  localparam int unsigned SLOT_W           = 16;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 16;
  localparam int unsigned ACC_W            = 2;

  localparam logic [PERSIST_W-1:0] PERSIST_RESET   = 8'd63;
  localparam logic [SLOT_W-1:0]    SLOT_TIME_RESET = 16'd100;
  localparam logic                 FULL_DUP_RESET  = 1'b0;

  localparam logic [ACC_W-1:0] ACC_IDLE      = 2'd0;
  localparam logic [ACC_W-1:0] ACC_WAIT_FREE = 2'd1;
  localparam logic [ACC_W-1:0] ACC_SLOT_WAIT = 2'd2;
  localparam logic [ACC_W-1:0] ACC_TX        = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERSISTENCE = 2'd0,
    CFG_SLOT_TIME   = 2'd1,
    CFG_FULL_DUPLEX = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_WAIT_FREE = 4'b0010,
    ST_SLOT_WAIT = 4'b0100,
    ST_TX        = 4'b1000
  } access_state_e;

  typedef struct packed {
    logic [PERSIST_W-1:0] persistence;
    logic [SLOT_W-1:0]    slot_time;
    logic                 full_duplex;
  } cfg_t;

  typedef struct packed {
    logic                frame_pending;
    logic                carrier_busy;
    logic                tx_finished;
    logic [RANDOM_W-1:0] random_value;
  } in_item_t;

  typedef struct packed {
    logic             ptt_on;
    logic             tx_start;
    logic             rx_indicator;
    logic [ACC_W-1:0] access_state;
  } out_item_t;

endpackage

>>> src/ppca_in_if.sv
// Interface: tick item channel into the channel access controller.
interface ppca_in_if;
  logic       valid;
  logic       ready;
  logic       frame_pending;
  logic       carrier_busy;
  logic       tx_finished;
  logic [7:0] random_value;

  modport source (
    output valid, frame_pending, carrier_busy, tx_finished, random_value,
    input  ready
  );
  modport sink (
    input  valid, frame_pending, carrier_busy, tx_finished, random_value,
    output ready
  );
endinterface

>>> src/ppca_out_if.sv
// Interface: result item channel out of the channel access controller.
interface ppca_out_if;
  logic       valid;
  logic       ready;
  logic       ptt_on;
  logic       tx_start;
  logic       rx_indicator;
  logic [1:0] access_state;

  modport source (
    output valid, ptt_on, tx_start, rx_indicator, access_state,
    input  ready
  );
  modport sink (
    input  valid, ptt_on, tx_start, rx_indicator, access_state,
    output ready
  );
endinterface

>>> src/ppca_cfg.sv
// Configuration register file: persistence, slot time and full duplex.
module ppca_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ppca_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ppca_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output ppca_pkg::cfg_t                      cfg_o
);
  import ppca_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PERSISTENCE: cfg_d.persistence = cfg_data_i[PERSIST_W-1:0];
        CFG_SLOT_TIME:   cfg_d.slot_time   = cfg_data_i[SLOT_W-1:0];
        CFG_FULL_DUPLEX: cfg_d.full_duplex = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.persistence <= PERSIST_RESET;
      cfg_q.slot_time   <= SLOT_TIME_RESET;
      cfg_q.full_duplex <= FULL_DUP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/ppca_ctrl.sv
// Access state machine: slot counter, PTT level and per-tick result logic.
module ppca_ctrl #(
  parameter int unsigned RandomRange = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  ppca_pkg::in_item_t    item_i,
  input  ppca_pkg::cfg_t        cfg_i,
  output ppca_pkg::out_item_t   res_o
);
  import ppca_pkg::*;

  localparam int unsigned LutDepth = RAND_BYTE_MAX + 1;

  access_state_e      state_q, state_d;
  logic [SLOT_W-1:0]  cnt_q, cnt_d;
  logic               ptt_q, ptt_d;
  logic               start;
  logic [RANDOM_W-1:0] draw;
  logic [ACC_W-1:0]   acc_code;

  // Draw reduced modulo the random range; table fixed at elaboration.
  logic [RANDOM_W-1:0] draw_lut [LutDepth];
  for (genvar g = 0; g < LutDepth; g++) begin : g_lut
    assign draw_lut[g] = RANDOM_W'(g % RandomRange);
  end
  assign draw = draw_lut[item_i.random_value];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptt_d   = ptt_q;
    start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_i.frame_pending) begin
          if (cfg_i.full_duplex || !item_i.carrier_busy) begin
            state_d = ST_TX;
            ptt_d   = 1'b1;
            start   = 1'b1;
          end else begin
            state_d = ST_WAIT_FREE;
          end
        end
      end
      ST_WAIT_FREE: begin
        if (!item_i.carrier_busy) begin
          if (draw > cfg_i.persistence) begin
            cnt_d   = cfg_i.slot_time;
            state_d = ST_SLOT_WAIT;
          end else begin
            state_d = ST_TX;
            ptt_d   = 1'b1;
            start   = 1'b1;
          end
        end
      end
      ST_SLOT_WAIT: begin
        if (item_i.carrier_busy) begin
          state_d = ST_WAIT_FREE;
        end else if (cnt_q == '0) begin
          state_d = ST_TX;
          ptt_d   = 1'b1;
          start   = 1'b1;
        end else begin
          cnt_d = cnt_q - SLOT_W'(1);
        end
      end
      ST_TX: begin
        if (item_i.tx_finished) begin
          state_d = ST_IDLE;
          ptt_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
        ptt_d   = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (state_d)
      ST_IDLE:      acc_code = ACC_IDLE;
      ST_WAIT_FREE: acc_code = ACC_WAIT_FREE;
      ST_SLOT_WAIT: acc_code = ACC_SLOT_WAIT;
      ST_TX:        acc_code = ACC_TX;
      default:      acc_code = ACC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ptt_q   <= 1'b0;
    end else if (step_i) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptt_q   <= ptt_d;
    end
  end

  assign res_o.ptt_on       = ptt_d;
  assign res_o.tx_start     = start;
  assign res_o.rx_indicator = item_i.carrier_busy;
  assign res_o.access_state = acc_code;

endmodule

>>> src/p_persistent_channel_access.sv
// Top level: p-persistent CSMA channel access controller for a packet radio modem.
// One tick item goes in, one result item comes out. An item is registered on
// entry; the state machine reads it there and commits its update as the result
// lands in an output register. A new tick can be taken every clock while the
// result side is ready, so sustained rate is one item per cycle when nothing
// stalls. The input register keeps taking items while a result waits, as long
// as the output register is freed in the same cycle. Random bytes are reduced
// modulo RANDOM_RANGE through a constant table before the persistence compare.
module p_persistent_channel_access #(
  parameter int unsigned RANDOM_RANGE = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ppca_in_if.sink                          in_i,
  ppca_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [ppca_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ppca_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ppca_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item;
  in_item_t  s1_item_q;
  logic      s1_valid_q;
  logic      s1_adv;
  out_item_t res;
  out_item_t out_item_q;
  logic      out_valid_q;

  assign in_item.frame_pending = in_i.frame_pending;
  assign in_item.carrier_busy  = in_i.carrier_busy;
  assign in_item.tx_finished   = in_i.tx_finished;
  assign in_item.random_value  = in_i.random_value;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  ppca_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ppca_ctrl #(
    .RandomRange (RANDOM_RANGE)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_item;
    end
    if (s1_adv) begin
      out_item_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.ptt_on       = out_item_q.ptt_on;
  assign out_o.tx_start     = out_item_q.tx_start;
  assign out_o.rx_indicator = out_item_q.rx_indicator;
  assign out_o.access_state = out_item_q.access_state;

  // PTT level tracks the transmitting state exactly.
  a_ptt_tx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_item_q.ptt_on == (out_item_q.access_state == ACC_TX)))
    else $error("ptt_on disagrees with access state");

  // A start pulse only comes with the transmitting state.
  a_start_tx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.tx_start) |-> (out_item_q.access_state == ACC_TX))
    else $error("tx_start outside transmitting");

  // A held entry item stays put until it moves on.
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("entry item lost while stalled");

  // A result is only replaced once it has been taken.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_item_q)))
    else $error("result overwritten while stalled");

endmodule

>>> sim/ppca_checker.sv
// Checker: tracks the controller's state and compares every result item with its prediction.
`timescale 1ns / 1ps
module ppca_checker
  import ppca_pkg::*;
#(
  parameter int unsigned RANDOM_RANGE = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ppca_in_if                    in_i,
  ppca_out_if                   out_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  cfg_t              regs;
  logic [ACC_W-1:0]  fsm_q;
  logic [SLOT_W-1:0] slot_cnt_q;
  logic              ptt_q;
  out_item_t         predicted_results[$];
  int                fails;

  function automatic out_item_t predict_tick(in_item_t t);
    out_item_t   r;
    logic        start;
    int unsigned draw;
    start = 1'b0;
    draw  = t.random_value % RANDOM_RANGE;
    case (fsm_q)
      ACC_IDLE: begin
        if (t.frame_pending) begin
          if (regs.full_duplex || !t.carrier_busy) begin
            fsm_q = ACC_TX;
            ptt_q = 1'b1;
            start = 1'b1;
          end else begin
            fsm_q = ACC_WAIT_FREE;
          end
        end
      end
      ACC_WAIT_FREE: begin
        if (!t.carrier_busy) begin
          if (draw > regs.persistence) begin
            slot_cnt_q = regs.slot_time;
            fsm_q      = ACC_SLOT_WAIT;
          end else begin
            fsm_q = ACC_TX;
            ptt_q = 1'b1;
            start = 1'b1;
          end
        end
      end
      ACC_SLOT_WAIT: begin
        if (t.carrier_busy) begin
          fsm_q = ACC_WAIT_FREE;
        end else if (slot_cnt_q == '0) begin
          fsm_q = ACC_TX;
          ptt_q = 1'b1;
          start = 1'b1;
        end else begin
          slot_cnt_q = slot_cnt_q - 1'b1;
        end
      end
      default: begin
        if (t.tx_finished) begin
          ptt_q = 1'b0;
          fsm_q = ACC_IDLE;
        end
      end
    endcase
    r.ptt_on       = ptt_q;
    r.tx_start     = start;
    r.rx_indicator = t.carrier_busy;
    r.access_state = fsm_q;
    return r;
  endfunction

  task automatic check_result(out_item_t exp);
    if (out_i.ptt_on !== exp.ptt_on) begin
      $error("ptt_on: expected %0b, got %0b", exp.ptt_on, out_i.ptt_on);
      fails++;
    end
    if (out_i.tx_start !== exp.tx_start) begin
      $error("tx_start: expected %0b, got %0b", exp.tx_start, out_i.tx_start);
      fails++;
    end
    if (out_i.rx_indicator !== exp.rx_indicator) begin
      $error("rx_indicator: expected %0b, got %0b", exp.rx_indicator, out_i.rx_indicator);
      fails++;
    end
    if (out_i.access_state !== exp.access_state) begin
      $error("access_state: expected %0d, got %0d", exp.access_state, out_i.access_state);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.persistence = PERSIST_RESET;
      regs.slot_time   = SLOT_TIME_RESET;
      regs.full_duplex = FULL_DUP_RESET;
      fsm_q            = ACC_IDLE;
      slot_cnt_q       = '0;
      ptt_q            = 1'b0;
      predicted_results.delete();
      fails            = 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        predicted_results.push_back(predict_tick('{in_i.frame_pending, in_i.carrier_busy,
                                                   in_i.tx_finished, in_i.random_value}));
      end
      if (out_i.valid && out_i.ready) begin
        if (predicted_results.size() == 0) begin
          $error("result item with no expectation pending");
          fails++;
        end else begin
          check_result(predicted_results.pop_front());
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PERSISTENCE: regs.persistence = cfg_data_i[PERSIST_W-1:0];
          CFG_SLOT_TIME:   regs.slot_time   = cfg_data_i[SLOT_W-1:0];
          CFG_FULL_DUPLEX: regs.full_duplex = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= predicted_results.size();
  end

endmodule

>>> sim/testbench.sv
// Testbench top: clock, reset, tick stimulus, result back-pressure and the final verdict.
`timescale 1ns / 1ps
module testbench;
  import ppca_pkg::*;

  localparam int unsigned RANDOM_RANGE = 256;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 112;
  localparam int RX_HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES   = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    tx_idle_pct;
  int                    rx_idle_pct;
  logic                  rx_hold_req;
  logic [PERSIST_W-1:0]  cur_persist;

  logic [PERSIST_W-1:0] phase_persist [PHASES] = '{8'd0, 8'd255, 8'd250, 8'd128, 8'd63, 8'd20};
  logic [SLOT_W-1:0]    phase_slot    [PHASES] = '{16'd0, 16'd65535, 16'd65535, 16'd4, 16'd1,
                                                   16'd7};
  logic                 phase_fd      [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

  ppca_in_if  tick_if ();
  ppca_out_if result_if ();

  p_persistent_channel_access #(
    .RANDOM_RANGE(RANDOM_RANGE)
  ) i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (tick_if),
    .out_o     (result_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  ppca_checker #(
    .RANDOM_RANGE(RANDOM_RANGE)
  ) i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (tick_if),
    .out_i       (result_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        for (int n = 0; n < RX_HOLD_CYCLES; n++) begin
          result_if.ready <= 1'b0;
          @(posedge clk);
        end
      end
      result_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_tick(input logic pend, input logic busy, input logic fin,
                           input logic [RANDOM_W-1:0] rv);
    while ($urandom_range(99) < tx_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk);
    end
    tick_if.valid         <= 1'b1;
    tick_if.frame_pending <= pend;
    tick_if.carrier_busy  <= busy;
    tick_if.tx_finished   <= fin;
    tick_if.random_value  <= rv;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
  endtask

  task automatic drain();
    tick_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [PERSIST_W-1:0] p, input logic [SLOT_W-1:0] s,
                          input logic fd);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_PERSISTENCE;
    cfg_data <= {8'($urandom), p};
    @(posedge clk);
    cfg_idx  <= CFG_SLOT_TIME;
    cfg_data <= s;
    @(posedge clk);
    cfg_idx  <= CFG_FULL_DUPLEX;
    cfg_data <= {15'($urandom), fd};
    @(posedge clk);
    cfg_idx  <= CFG_UNUSED_IDX;
    cfg_data <= 16'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_persist = p;
  endtask

  initial begin
    logic                carrier_lvl;
    logic [RANDOM_W-1:0] rv;
    carrier_lvl = 1'b0;
    cur_persist = PERSIST_RESET;
    rst_n = 1'b0;
    tick_if.valid         <= 1'b0;
    tick_if.frame_pending <= 1'b0;
    tick_if.carrier_busy  <= 1'b0;
    tick_if.tx_finished   <= 1'b0;
    tick_if.random_value  <= '0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_PERSISTENCE;
    cfg_data    <= '0;
    rx_hold_req <= 1'b0;
    tx_idle_pct = 22;
    rx_idle_pct <= 71;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: draw exactly at persistence transmits
    send_tick(1'b1, 1'b1, 1'b0, 8'd0);
    send_tick(1'b0, 1'b0, 1'b0, 8'd63);
    send_tick(1'b0, 1'b0, 1'b1, 8'd0);

    set_regs(8'd100, 16'd2, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1, 8'd255);
    send_tick(1'b1, 1'b0, 1'b0, 8'd0);
    send_tick(1'b1, 1'b1, 1'b0, 8'd200);
    send_tick(1'b0, 1'b0, 1'b1, 8'd0);
    send_tick(1'b1, 1'b1, 1'b1, 8'd0);
    send_tick(1'b0, 1'b0, 1'b0, 8'd100);
    send_tick(1'b0, 1'b0, 1'b1, 8'd0);
    send_tick(1'b1, 1'b1, 1'b0, 8'd0);
    send_tick(1'b0, 1'b0, 1'b0, 8'd101);
    send_tick(1'b0, 1'b0, 1'b0, 8'd0);
    // carrier returns mid-slot, then a failed draw reloads the counter
    send_tick(1'b1, 1'b1, 1'b0, 8'd0);
    send_tick(1'b0, 1'b0, 1'b0, 8'd255);
    send_tick(1'b0, 1'b0, 1'b0, 8'd0);
    send_tick(1'b0, 1'b0, 1'b0, 8'd0);
    send_tick(1'b0, 1'b0, 1'b0, 8'd0);
    send_tick(1'b0, 1'b0, 1'b1, 8'd0);

    set_regs(8'd100, 16'd2, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0, 8'd255);
    send_tick(1'b0, 1'b1, 1'b1, 8'd0);

    // zero slot time: transmit on the tick after the failed draw
    set_regs(8'd0, 16'd0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 8'd0);
    send_tick(1'b0, 1'b0, 1'b0, 8'd1);
    send_tick(1'b0, 1'b0, 1'b0, 8'd0);
    send_tick(1'b0, 1'b0, 1'b1, 8'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_regs(phase_persist[ph], phase_slot[ph], phase_fd[ph]);
      case (ph / 2)
        0: begin
          tx_idle_pct = 22;
          rx_idle_pct <= 71;
        end
        1: begin
          tx_idle_pct = 71;
          rx_idle_pct <= 22;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      if (ph == 4) rx_hold_req <= 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == PHASE_ITEMS / 2) drain();
        if ($urandom_range(99) < 15) carrier_lvl = ~carrier_lvl;
        if ($urandom_range(99) < 10) begin
          send_tick(1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
        end else begin
          rv = $urandom_range(1) ? 8'($urandom) : cur_persist + 8'($urandom_range(4)) - 8'd2;
          send_tick($urandom_range(99) < 40, carrier_lvl, $urandom_range(99) < 20, rv);
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
